// File: rtl/dst_pkg.sv
`default_nettype none

package dst_pkg;

  // Longest string that is split; offsets saturate here.
  localparam int MAX_LEN = 65536;
  // Characters available in each of the delimiter and trim sets.
  localparam int SET_SIZE = 4;

  // A 32-bit set register holds four bytes at most.
  localparam int SET_LANES = (SET_SIZE < 4) ? SET_SIZE : 4;

  // Position counter must hold MAX_LEN itself.
  localparam int POS_W = $clog2(MAX_LEN + 1);

  localparam int BYTE_W  = 8;
  localparam int START_W = 16;
  localparam int END_W   = 17;
  localparam int CNT_W   = 16;
  localparam int CNTC_W  = 3;
  localparam int SET_W   = 32;
  localparam int IDX_W   = 2;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register map of the configuration port.
  typedef enum logic [IDX_W-1:0] {
    REG_DELIM_COUNT = 2'd0,
    REG_DELIM_SET   = 2'd1,
    REG_TRIM_COUNT  = 2'd2,
    REG_TRIM_SET    = 2'd3
  } reg_idx_t;

  // Classification of the byte held in the input stage.
  typedef struct packed {
    logic is_delim;
    logic is_trim;
    logic last;
  } cls_t;

  // One result item.
  typedef struct packed {
    logic               token_valid;
    logic [START_W-1:0] token_start;
    logic [END_W-1:0]   token_end;
    logic [CNT_W-1:0]   token_count;
    logic               string_done;
    logic               length_overflow;
  } rsl_t;

endpackage

`default_nettype wire

// File: rtl/dst_set_match.sv
`default_nettype none

module dst_set_match import dst_pkg::*; (
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [SET_W-1:0]  set_bytes,
  input  wire logic [CNTC_W-1:0] set_count,
  output logic                   hit
);

  // Compare the byte against every active lane in parallel.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < SET_LANES; i++) begin
      if ((set_count > CNTC_W'(i)) && (set_bytes[BYTE_W*i +: BYTE_W] == data_byte)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/dst_tracker.sv
`default_nettype none

module dst_tracker import dst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic item_valid,
  input  wire cls_t item_cls,
  input  wire logic retire,
  output logic      emit,
  output rsl_t      rsl
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             have_r, have_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic             ovf_now, delim_hit, keep, tok_close, valid, have_upd;
  logic [POS_W-1:0] start_upd, end_upd;
  logic [CNT_W-1:0] cnt_upd;

  always_comb begin
    // Bytes past the length limit only mark overflow.
    ovf_now   = (pos_r >= MAX_POS);
    delim_hit = !ovf_now && item_cls.is_delim;
    keep      = !ovf_now && !item_cls.is_delim && !item_cls.is_trim;

    have_upd  = have_r || keep;
    start_upd = (keep && !have_r) ? pos_r : start_r;
    end_upd   = keep ? (pos_r + POS_W'(1)) : end_r;

    tok_close = delim_hit && have_r;
    valid     = tok_close || (item_cls.last && have_upd);
    emit      = item_valid && (tok_close || item_cls.last);

    cnt_upd   = (valid && (cnt_r != CNT_MAX)) ? (cnt_r + CNT_W'(1)) : cnt_r;

    rsl.token_valid     = valid;
    rsl.token_start     = valid ? START_W'(start_upd) : '0;
    rsl.token_end       = valid ? END_W'(end_upd) : '0;
    rsl.token_count     = cnt_upd;
    rsl.string_done     = item_cls.last;
    rsl.length_overflow = ovf_r || ovf_now;

    pos_nxt   = pos_r;
    have_nxt  = have_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    if (item_valid && retire) begin
      if (item_cls.last) begin
        // End of string: return to the reset state.
        pos_nxt   = '0;
        have_nxt  = 1'b0;
        start_nxt = '0;
        end_nxt   = '0;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else begin
        pos_nxt   = ovf_now ? pos_r : (pos_r + POS_W'(1));
        have_nxt  = valid ? 1'b0 : have_upd;
        start_nxt = start_upd;
        end_nxt   = end_upd;
        cnt_nxt   = cnt_upd;
        ovf_nxt   = ovf_r || ovf_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      have_r  <= 1'b0;
      start_r <= '0;
      end_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      have_r  <= have_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/delimiter_set_tokenizer_core.sv
// Channel | Direction | Handshake          | Payload
// in_     | in        | in_valid/in_stall  | in_data_byte, in_last_byte
// out_    | out       | out_valid/out_stall| out_token_valid .. out_length_overflow
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock sustained while out_ is not stalled. An item is held in the
// input register, where the set compares and the string tracker run, and its
// result (if any) is loaded from there into the output register.
// rst_n is synchronous and active low; it clears the stage valids, the string
// tracker and the configuration (one newline delimiter, no trim characters).
// A stall on out_ holds the output register; the input stage still retires
// items that give no result, and only stalls in_ when its item has one.
`default_nettype none

module delimiter_set_tokenizer_core import dst_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [BYTE_W-1:0]  in_data_byte,
  input  wire logic               in_last_byte,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_token_valid,
  output logic [START_W-1:0]      out_token_start,
  output logic [END_W-1:0]        out_token_end,
  output logic [CNT_W-1:0]        out_token_count,
  output logic                    out_string_done,
  output logic                    out_length_overflow,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [SET_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [CNTC_W-1:0] delim_count_r;
  logic [SET_W-1:0]  delim_set_r;
  logic [CNTC_W-1:0] trim_count_r;
  logic [SET_W-1:0]  trim_set_r;

  // Input stage.
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Output stage.
  logic              out_valid_r, out_valid_nxt;
  rsl_t              out_r;

  logic              in_take, out_free, emit, retire, out_load;
  logic              delim_hit, trim_hit;
  cls_t              cls;
  rsl_t              rsl;

  // Writes must only be made while the block is idle; the block does not enforce this and takes them all.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_count_r <= CNTC_W'(1);
      delim_set_r   <= SET_W'(10);
      trim_count_r  <= '0;
      trim_set_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_DELIM_COUNT: delim_count_r <= cfg_data[CNTC_W-1:0];
        REG_DELIM_SET:   delim_set_r   <= cfg_data;
        REG_TRIM_COUNT:  trim_count_r  <= cfg_data[CNTC_W-1:0];
        REG_TRIM_SET:    trim_set_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the held byte against both sets.
  dst_set_match u_delim (
    .data_byte (s1_byte_r),
    .set_bytes (delim_set_r),
    .set_count (delim_count_r),
    .hit       (delim_hit)
  );

  dst_set_match u_trim (
    .data_byte (s1_byte_r),
    .set_bytes (trim_set_r),
    .set_count (trim_count_r),
    .hit       (trim_hit)
  );

  // A delimiter wins over a trim match inside the tracker.
  assign cls = '{is_delim: delim_hit, is_trim: trim_hit, last: s1_last_r};

  dst_tracker u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item_cls   (cls),
    .retire     (retire),
    .emit       (emit),
    .rsl        (rsl)
  );

  // Output register is free when empty or drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Retire the held item unless its result has nowhere to go.
  assign retire   = !emit || out_free;
  assign out_load = s1_valid_r && emit && out_free;
  assign in_stall = s1_valid_r && !retire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_valid_r && retire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on handshake, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (out_load) begin
      out_r <= rsl;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_token_valid     = out_r.token_valid;
  assign out_token_start     = out_r.token_start;
  assign out_token_end       = out_r.token_end;
  assign out_token_count     = out_r.token_count;
  assign out_string_done     = out_r.string_done;
  assign out_length_overflow = out_r.length_overflow;

endmodule

`default_nettype wire

// File: rtl/dst_checker.sv
`default_nettype none

module dst_checker import dst_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               out_token_valid,
  input  wire logic [START_W-1:0] out_token_start,
  input  wire logic [END_W-1:0]   out_token_end,
  input  wire logic [CNT_W-1:0]   out_token_count,
  input  wire logic               out_string_done,
  input  wire logic               out_length_overflow
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_valid)
      && $stable(out_token_start) && $stable(out_token_end)
      && $stable(out_token_count) && $stable(out_string_done)
      && $stable(out_length_overflow))
    else $error("stalled result changed");

  // A reported token spans at least one kept byte.
  a_token_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_valid |-> out_token_end > END_W'(out_token_start))
    else $error("token end not past start");

  // A done result without a token carries zero offsets.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_token_valid |-> out_string_done && out_token_start == '0
      && out_token_end == '0)
    else $error("empty result malformed");

  // A reported token is counted.
  a_token_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_valid |-> out_token_count != '0)
    else $error("token with zero count");

endmodule

bind delimiter_set_tokenizer_core dst_checker u_dst_checker (.*);

`default_nettype wire
